>>> rtl/swf_pkg.sv
// swf_pkg: shared types and constants of the streaming word filter
`timescale 1ns / 1ps

package swf_pkg;

	localparam int NUM_LETTERS = 26;
	localparam int LETTER_W    = 5;
	localparam int LEN_W       = 6;
	localparam int PCNT_W      = 5;
	localparam int WCNT_W      = 6;
	localparam int MODE_W      = 3;

	localparam logic [PCNT_W-1:0] PCNT_MAX = '1;
	localparam logic [WCNT_W-1:0] WCNT_MAX = '1;

	// register indexes on the configuration port
	localparam logic REG_FILTER_MODE   = 1'b0;
	localparam logic REG_TARGET_LENGTH = 1'b1;

	typedef enum logic [MODE_W-1:0] {
		MODE_CONTAINS = 3'd0,
		MODE_EXCLUDES = 3'd1,
		MODE_LENGTH   = 3'd2,
		MODE_PREFIX   = 3'd3,
		MODE_SUFFIX   = 3'd4,
		MODE_INTERIOR = 3'd5,
		MODE_ANYWHERE = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNCATED = 2'd1,
		ST_TOO_LONG  = 2'd2
	} status_t;

	localparam logic ACT_PATTERN = 1'b0;
	localparam logic ACT_WORD    = 1'b1;

endpackage

>>> rtl/swf_item_if.sv
// swf_item_if: letter channel into the word filter
`timescale 1ns / 1ps

interface swf_item_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [swf_pkg::LETTER_W-1:0]  letter;
	logic                          last;

	modport source (output valid, output action, output letter, output last, input ready);
	modport sink   (input valid, input action, input letter, input last, output ready);
endinterface

>>> rtl/swf_result_if.sv
// swf_result_if: verdict channel out of the word filter
`timescale 1ns / 1ps

interface swf_result_if;
	logic                       valid;
	logic                       ready;
	logic                       accept;
	logic [swf_pkg::LEN_W-1:0]  word_length;
	swf_pkg::status_t           status;

	modport source (output valid, output accept, output word_length, output status, input ready);
	modport sink   (input valid, input accept, input word_length, input status, output ready);
endinterface

>>> rtl/streaming_word_filter_core.sv
// streaming_word_filter_core: letter-stream word filter with pattern and verdict logic
`timescale 1ns / 1ps

// channel   dir  transfer moves                          handshake
// item      in   action, letter, last (one letter)      valid / ready
// result    out  accept, word_length, status (per word) valid / ready
// apb       in   filter_mode, target_length writes      psel / penable / pready
//
// one letter per cycle unless a word-ending letter is held: a letter lands in the
// input register, and the match, count and verdict logic then write the state and
// the result register
// a word-ending letter passes through the input register before the result
// register loads, and the result transfer is made from the result register
// a word-ending letter waits in the input register only while the result
// register is full and not being taken; other letters keep flowing
// async active-low reset clears control state; the pattern store is not reset

module streaming_word_filter_core #(
	parameter int MAX_PATTERN = 16,
	parameter int MAX_WORD    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	swf_item_if.sink            item,
	swf_result_if.source        result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int PL_W  = $clog2(MAX_PATTERN + 1);
	localparam int PI_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_W = swf_pkg::LEN_W;
	localparam int NL    = swf_pkg::NUM_LETTERS;

	localparam logic [LEN_W-1:0] MAX_WORD_L    = LEN_W'(MAX_WORD);
	localparam logic [LEN_W-1:0] MAX_PATTERN_L = LEN_W'(MAX_PATTERN);
	localparam logic [PL_W-1:0]  MAX_PATTERN_P = PL_W'(MAX_PATTERN);

	// configuration registers
	logic [swf_pkg::MODE_W-1:0] mode_q;
	logic [LEN_W-1:0]           target_len_q;

	// input register
	logic                         valid_s1;
	logic                         action_s1;
	logic [swf_pkg::LETTER_W-1:0] letter_s1;
	logic                         last_s1;

	// pattern state
	logic [swf_pkg::LETTER_W-1:0] store_q [MAX_PATTERN];
	logic [PL_W-1:0]              plen_q;
	logic [swf_pkg::PCNT_W-1:0]   pcnt_q [NL];
	logic                         pclosed_q;
	logic                         ptrunc_q;

	// word state; match_q[j] means pattern letters 0..j end at the newest letter
	logic [swf_pkg::WCNT_W-1:0]   wcnt_q [NL];
	logic [LEN_W-1:0]             wlen_q;
	logic [MAX_PATTERN-1:0]       match_q;
	logic                         prefix_ok_q;
	logic                         found_any_q;
	logic                         found_int_q;
	logic                         too_long_q;

	// result register
	logic                         res_valid_q;
	logic                         res_accept_q;
	logic [LEN_W-1:0]             res_len_q;
	swf_pkg::status_t             res_status_q;

	logic                         produces;
	logic                         advance;
	logic                         take_in;

	// next-state values
	logic [PL_W-1:0]              pl_base;
	logic [PL_W-1:0]              plen_nx;
	logic                         ptrunc_nx;
	logic                         store_we;
	logic [PI_W-1:0]              store_wa;
	logic [swf_pkg::PCNT_W-1:0]   pcnt_nx [NL];
	logic [swf_pkg::WCNT_W-1:0]   wcnt_nx [NL];
	logic [LEN_W-1:0]             wlen_nx;
	logic [MAX_PATTERN-1:0]       match_nx;
	logic [PI_W-1:0]              pidx;
	logic                         ends_here;
	logic                         prefix_nx;
	logic                         found_any_nx;
	logic                         found_int_nx;
	logic                         too_long_nx;
	logic                         has_all;
	logic                         empty_pat;
	logic                         verdict;
	swf_pkg::status_t             status_nx;

	// ---------------------------------------------------------------
	// handshake: only a word-ending letter needs room in the result register
	// ---------------------------------------------------------------
	assign produces   = action_s1 && last_s1;
	assign advance    = valid_s1 && (!produces || !res_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take_in    = item.valid && item.ready;

	assign result.valid       = res_valid_q;
	assign result.accept      = res_accept_q;
	assign result.word_length = res_len_q;
	assign result.status      = res_status_q;

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			swf_pkg::REG_FILTER_MODE:   prdata = 32'(mode_q);
			swf_pkg::REG_TARGET_LENGTH: prdata = 32'(target_len_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			target_len_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				swf_pkg::REG_FILTER_MODE:   mode_q       <= pwdata[swf_pkg::MODE_W-1:0];
				swf_pkg::REG_TARGET_LENGTH: target_len_q <= pwdata[LEN_W-1:0];
				default:                    ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// pattern side: a letter after a closed pattern starts a fresh one
	// ---------------------------------------------------------------
	always_comb begin
		pl_base   = pclosed_q ? '0 : plen_q;
		ptrunc_nx = pclosed_q ? 1'b0 : ptrunc_q;
		store_we  = 1'b0;
		store_wa  = pl_base[PI_W-1:0];
		plen_nx   = pl_base;
		if (pl_base < MAX_PATTERN_P) begin
			store_we = 1'b1;
			plen_nx  = pl_base + PL_W'(1);
		end else begin
			ptrunc_nx = 1'b1;
		end
		for (int k = 0; k < NL; k++) begin
			pcnt_nx[k] = pclosed_q ? '0 : pcnt_q[k];
			// codes above z are stored but not counted
			if (letter_s1 == swf_pkg::LETTER_W'(k) && pcnt_nx[k] != swf_pkg::PCNT_MAX)
				pcnt_nx[k] = pcnt_nx[k] + swf_pkg::PCNT_W'(1);
		end
	end

	// ---------------------------------------------------------------
	// word side: shift-and matcher, prefix tracker, counters
	// ---------------------------------------------------------------
	assign pidx      = PI_W'(plen_q - PL_W'(1));
	assign empty_pat = (plen_q == '0);

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (j == 0)
				match_nx[j] = (store_q[j] == letter_s1);
			else
				match_nx[j] = match_q[j-1] && (store_q[j] == letter_s1);
		end

		// occurrence that ended one letter ago, did not start at the first
		// letter, and now has a letter after it
		found_int_nx = found_int_q;
		if (!empty_pat && wlen_q > LEN_W'(plen_q) && match_q[pidx])
			found_int_nx = 1'b1;

		prefix_nx = prefix_ok_q;
		if (wlen_q < LEN_W'(plen_q) && wlen_q < MAX_PATTERN_L &&
		    store_q[wlen_q[PI_W-1:0]] != letter_s1)
			prefix_nx = 1'b0;

		for (int k = 0; k < NL; k++) begin
			wcnt_nx[k] = wcnt_q[k];
			if (letter_s1 == swf_pkg::LETTER_W'(k) && wcnt_q[k] != swf_pkg::WCNT_MAX)
				wcnt_nx[k] = wcnt_q[k] + swf_pkg::WCNT_W'(1);
		end

		too_long_nx = too_long_q;
		wlen_nx     = wlen_q;
		if (wlen_q >= MAX_WORD_L)
			too_long_nx = 1'b1;
		else
			wlen_nx = wlen_q + LEN_W'(1);

		ends_here = (wlen_nx >= LEN_W'(plen_q)) && (empty_pat || match_nx[pidx]);

		found_any_nx = found_any_q || ends_here;
	end

	// ---------------------------------------------------------------
	// verdict at the last letter of a word
	// ---------------------------------------------------------------
	always_comb begin
		has_all = 1'b1;
		for (int k = 0; k < NL; k++) begin
			if (wcnt_nx[k] < {1'b0, pcnt_q[k]})
				has_all = 1'b0;
		end

		case (mode_q)
			swf_pkg::MODE_CONTAINS: verdict = has_all;
			swf_pkg::MODE_EXCLUDES: verdict = !has_all;
			swf_pkg::MODE_LENGTH:   verdict = (wlen_nx == target_len_q);
			swf_pkg::MODE_PREFIX:
				verdict = empty_pat || (prefix_nx && wlen_nx >= LEN_W'(plen_q));
			swf_pkg::MODE_SUFFIX:   verdict = empty_pat || ends_here;
			swf_pkg::MODE_INTERIOR: verdict = empty_pat || found_int_nx;
			swf_pkg::MODE_ANYWHERE: verdict = empty_pat || found_any_nx;
			default:                verdict = 1'b0;
		endcase

		// an overlong word is always rejected and outranks a truncated pattern
		if (too_long_nx) begin
			status_nx = swf_pkg::ST_TOO_LONG;
			verdict   = 1'b0;
		end else if (ptrunc_q) begin
			status_nx = swf_pkg::ST_TRUNCATED;
		end else begin
			status_nx = swf_pkg::ST_OK;
		end
	end

	// ---------------------------------------------------------------
	// input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= item.action;
			letter_s1 <= item.letter;
			last_s1   <= item.last;
		end
	end

	// pattern store holds garbage until written; only stored entries matter
	always_ff @(posedge clk) begin
		if (advance && action_s1 == swf_pkg::ACT_PATTERN && store_we)
			store_q[store_wa] <= letter_s1;
	end

	// ---------------------------------------------------------------
	// filter state
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q      <= '0;
			pclosed_q   <= 1'b1;
			ptrunc_q    <= 1'b0;
			wlen_q      <= '0;
			match_q     <= '0;
			prefix_ok_q <= 1'b1;
			found_any_q <= 1'b0;
			found_int_q <= 1'b0;
			too_long_q  <= 1'b0;
			for (int k = 0; k < NL; k++) begin
				pcnt_q[k] <= '0;
				wcnt_q[k] <= '0;
			end
		end else if (advance) begin
			if (action_s1 == swf_pkg::ACT_PATTERN || last_s1) begin
				// a pattern letter drops any partial word; a word end starts over
				wlen_q      <= '0;
				match_q     <= '0;
				prefix_ok_q <= 1'b1;
				found_any_q <= 1'b0;
				found_int_q <= 1'b0;
				too_long_q  <= 1'b0;
				for (int k = 0; k < NL; k++)
					wcnt_q[k] <= '0;
			end else begin
				wlen_q      <= wlen_nx;
				match_q     <= match_nx;
				prefix_ok_q <= prefix_nx;
				found_any_q <= found_any_nx;
				found_int_q <= found_int_nx;
				too_long_q  <= too_long_nx;
				for (int k = 0; k < NL; k++)
					wcnt_q[k] <= wcnt_nx[k];
			end

			if (action_s1 == swf_pkg::ACT_PATTERN) begin
				plen_q    <= plen_nx;
				ptrunc_q  <= ptrunc_nx;
				pclosed_q <= last_s1;
				for (int k = 0; k < NL; k++)
					pcnt_q[k] <= pcnt_nx[k];
			end else begin
				// any word letter closes an unfinished pattern
				pclosed_q <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// result register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && produces) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			res_accept_q <= verdict;
			res_len_q    <= wlen_nx;
			res_status_q <= status_nx;
		end
	end

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_too_long_rejects: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_status_q == swf_pkg::ST_TOO_LONG |-> !res_accept_q)
		else $error("overlong word given an accept");

	a_len_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_len_q <= MAX_WORD_L)
		else $error("word length beyond maximum");

	a_plen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q <= MAX_PATTERN_P)
		else $error("pattern length beyond store depth");

	a_pattern_clears_word: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 == swf_pkg::ACT_PATTERN |=> wlen_q == '0 && match_q == '0)
		else $error("word state kept across a pattern letter");

	a_result_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !result.ready |=> res_valid_q && $stable(res_len_q))
		else $error("pending result overwritten");

endmodule
